// ----- sv/sem_pkg.sv -----
`default_nettype none

package sem_pkg;

    localparam int PIX_W   = 8;
    localparam int CHAN_N  = 3;
    localparam int ROW_N   = 3;
    localparam int COLS_W  = PIX_W + 2;        // weighted sum of one column or row
    localparam int GRAD_W  = COLS_W + 1;       // signed difference of two sums
    localparam int SUM_W   = 21;               // gx*gx + gy*gy, at most 2080800
    localparam int MAG_W   = 11;               // floor square root, at most 1442
    localparam int BYTE_W  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Highest even power of two that fits in SUM_W bits starts the root search.
    localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (SUM_W - 1);

    // One pixel, channels blue, green, red from index 0 up.
    typedef logic [CHAN_N-1:0][PIX_W-1:0] px_t;
    // One column, rows top, middle, bottom from index 0 up.
    typedef px_t [ROW_N-1:0] col_t;
    // Squared gradient sums of the three channels.
    typedef logic [CHAN_N-1:0][SUM_W-1:0] sums_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_MAX
    } back_state_t;

endpackage

`default_nettype wire

// ----- sv/sem_front.sv -----
`default_nettype none

module sem_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sem_pkg::col_t  in_col,
    input  wire logic           in_row_start,
    output logic                push_valid,
    input  wire logic           push_ready,
    output sem_pkg::sums_t      push_data
);
    import sem_pkg::*;

    col_t                     left_reg;
    col_t                     mid_reg;
    logic [1:0]               fill_reg;
    logic [1:0]               fill_next;
    logic                     st_valid_reg;
    logic signed [GRAD_W-1:0] gx_reg [CHAN_N];
    logic signed [GRAD_W-1:0] gy_reg [CHAN_N];
    logic signed [GRAD_W-1:0] gx_next [CHAN_N];
    logic signed [GRAD_W-1:0] gy_next [CHAN_N];
    logic                     accept;
    logic                     produce;

    assign in_ready = !st_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (in_row_start) begin
            fill_next = 2'd1;
        end else if (fill_reg != 2'd3) begin
            fill_next = fill_reg + 2'd1;
        end else begin
            fill_next = fill_reg;
        end
    end

    assign produce = (fill_next == 2'd3);

    // The new column is the right column of the window.
    always_comb begin
        logic [COLS_W-1:0] s_left, s_right, s_top, s_bot;
        for (int ch = 0; ch < CHAN_N; ch++) begin
            s_left  = COLS_W'(left_reg[0][ch]) + COLS_W'({left_reg[1][ch], 1'b0})
                    + COLS_W'(left_reg[2][ch]);
            s_right = COLS_W'(in_col[0][ch]) + COLS_W'({in_col[1][ch], 1'b0})
                    + COLS_W'(in_col[2][ch]);
            s_top   = COLS_W'(left_reg[0][ch]) + COLS_W'({mid_reg[0][ch], 1'b0})
                    + COLS_W'(in_col[0][ch]);
            s_bot   = COLS_W'(left_reg[2][ch]) + COLS_W'({mid_reg[2][ch], 1'b0})
                    + COLS_W'(in_col[2][ch]);
            gx_next[ch] = $signed({1'b0, s_left}) - $signed({1'b0, s_right});
            gy_next[ch] = $signed({1'b0, s_top}) - $signed({1'b0, s_bot});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= 2'd0;
            st_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
            end
            if (accept && produce) begin
                st_valid_reg <= 1'b1;
            end else if (push_ready) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg <= mid_reg;
            mid_reg  <= in_col;
        end
        if (accept && produce) begin
            for (int ch = 0; ch < CHAN_N; ch++) begin
                gx_reg[ch] <= gx_next[ch];
                gy_reg[ch] <= gy_next[ch];
            end
        end
    end

    always_comb begin
        logic signed [2*GRAD_W-1:0] sqx, sqy;
        for (int ch = 0; ch < CHAN_N; ch++) begin
            sqx = gx_reg[ch] * gx_reg[ch];
            sqy = gy_reg[ch] * gy_reg[ch];
            push_data[ch] = SUM_W'(sqx[SUM_W-1:0] + sqy[SUM_W-1:0]);
        end
    end

    assign push_valid = st_valid_reg;

endmodule

`default_nettype wire

// ----- sv/sem_queue.sv -----
`default_nettype none

module sem_queue #(
    parameter int DEPTH = sem_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire sem_pkg::sums_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output sem_pkg::sums_t      pop_data
);
    import sem_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sums_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sem_back.sv -----
`default_nettype none

module sem_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       pop_valid,
    output logic                            pop_ready,
    input  wire sem_pkg::sums_t             pop_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [sem_pkg::MAG_W-1:0]       out_mag
);
    import sem_pkg::*;

    back_state_t       state_reg, state_next;
    logic [SUM_W-1:0]  rem_reg [CHAN_N];
    logic [SUM_W-1:0]  rem_next [CHAN_N];
    logic [SUM_W-1:0]  res_reg [CHAN_N];
    logic [SUM_W-1:0]  res_next [CHAN_N];
    logic [SUM_W-1:0]  bit_reg, bit_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < CHAN_N; ch++) begin
            rem_reg[ch] <= rem_next[ch];
            res_reg[ch] <= res_next[ch];
        end
        bit_reg <= bit_next;
        mag_reg <= mag_next;
    end

    // Digit-by-digit square root, two bits of the radicand per cycle, all three
    // channels side by side.
    always_comb begin
        logic [SUM_W:0]   trial;
        logic [MAG_W-1:0] best;
        state_next = state_reg;
        bit_next   = bit_reg;
        mag_next   = mag_reg;
        valid_next = valid_reg;
        pop_ready  = 1'b0;
        best       = '0;
        trial      = '0;
        for (int ch = 0; ch < CHAN_N; ch++) begin
            rem_next[ch] = rem_reg[ch];
            res_next[ch] = res_reg[ch];
        end

        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    pop_ready = 1'b1;
                    for (int ch = 0; ch < CHAN_N; ch++) begin
                        rem_next[ch] = pop_data[ch];
                        res_next[ch] = '0;
                    end
                    bit_next   = ROOT_BIT_INIT;
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                for (int ch = 0; ch < CHAN_N; ch++) begin
                    trial = {1'b0, res_reg[ch]} + {1'b0, bit_reg};
                    if ({1'b0, rem_reg[ch]} >= trial) begin
                        rem_next[ch] = rem_reg[ch] - trial[SUM_W-1:0];
                        res_next[ch] = (res_reg[ch] >> 1) + bit_reg;
                    end else begin
                        res_next[ch] = res_reg[ch] >> 1;
                    end
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    state_next = BK_MAX;
                end
            end
            BK_MAX: begin
                if (!valid_reg || out_ready) begin
                    for (int ch = 0; ch < CHAN_N; ch++) begin
                        if (res_reg[ch][MAG_W-1:0] > best) begin
                            best = res_reg[ch][MAG_W-1:0];
                        end
                    end
                    mag_next   = best;
                    valid_next = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;

endmodule

`default_nettype wire

// ----- sv/sobel_edge_magnitude_3x3.sv -----
// Sobel edge magnitude over a sliding 3x3 window of RGB pixels.
// The s_ channel takes one column of three pixels (top, middle, bottom) per
// request; s_tuser marks the first column of a row. From the third column of a
// row on, every column yields one request on the m_ channel carrying the
// largest per-channel floor(sqrt(gx*gx + gy*gy)) and its low byte.
// Columns that yield no result are taken one per cycle while the gradient
// stage or the queue has room. A result is registered in the gradient stage
// when its column is taken and enters the queue when the queue has room; the
// square-root unit then loads it, runs 11 root steps of two bits each and
// picks the maximum, taking no new result until the last one is in the output
// register, so the sustained rate is set by that shared iterative square-root unit.
// A stalled m_tready holds the result in the output register; the queue then
// fills and s_tready drops once the gradient stage is also full.
// Reset (aresetn low, synchronous) empties the queue and the unit and
// restarts the column count, so three new columns are needed before the next result.
`default_nettype none

module sobel_edge_magnitude_3x3 #(
    parameter int QUEUE_DEPTH = sem_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // top_blue, top_green, top_red, mid_blue, mid_green, mid_red,
    // bot_blue, bot_green, bot_red, 8 bits each from the lowest bit up
    input  wire logic [71:0] s_tdata,
    // row_start
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // edge_magnitude [10:0], edge_byte [18:11], zero fill [23:19]
    output logic [23:0]      m_tdata
);
    import sem_pkg::*;

    col_t             in_col;
    logic             push_valid;
    logic             push_ready;
    sums_t            push_data;
    logic             pop_valid;
    logic             pop_ready;
    sums_t            pop_data;
    logic [MAG_W-1:0] mag;

    always_comb begin
        for (int r = 0; r < ROW_N; r++) begin
            for (int ch = 0; ch < CHAN_N; ch++) begin
                in_col[r][ch] = s_tdata[(r*CHAN_N + ch)*PIX_W +: PIX_W];
            end
        end
    end

    sem_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_col       (in_col),
        .in_row_start (s_tuser),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    sem_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sem_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mag   (mag)
    );

    assign m_tdata = {5'b0, mag[BYTE_W-1:0], mag};

endmodule

`default_nettype wire
